@@ hdl/pixel_false_color_mapper_macros.svh @@
// Assertion macros for the false color mapper checks.
`ifndef PIXEL_FALSE_COLOR_MAPPER_MACROS_SVH
`define PIXEL_FALSE_COLOR_MAPPER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PFCM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfcm check failed");

// next-cycle implication, clocked on clk, off during reset
`define PFCM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfcm check failed");

`endif

@@ hdl/pfcm_pkg.sv @@
// Shared constants, types and the heat colormap knot table.
`default_nettype none
package pfcm_pkg;

	localparam int PIXEL_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int PIX_W      = 16;
	localparam int CH_W       = 8;
	localparam int DEPTH_W    = 5;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 1'b1;

	localparam logic [MODE_W-1:0] MODE_GREY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SAT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HEAT = 2'd2;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef logic [CH_W-1:0] chan_t;
	typedef logic signed [CH_W:0] delta_t;

	function automatic chan_t heat_knot(input logic [3:0] idx, input logic [1:0] ch);
		logic [3*CH_W-1:0] rgb;
		begin
			case (idx)
				4'd0: rgb = {8'd0,   8'd0,   8'd0};
				4'd1: rgb = {8'd140, 8'd50,  8'd47};
				4'd2: rgb = {8'd255, 8'd196, 8'd0};
				4'd3: rgb = {8'd34,  8'd190, 8'd90};
				4'd4: rgb = {8'd0,   8'd225, 8'd255};
				4'd5: rgb = {8'd11,  8'd140, 8'd240};
				4'd6: rgb = {8'd0,   8'd0,   8'd255};
				4'd7: rgb = {8'd142, 8'd19,  8'd236};
				4'd8: rgb = {8'd255, 8'd255, 8'd255};
				default: rgb = '0;
			endcase
			case (ch)
				2'd0: heat_knot = rgb[CH_W-1:0];
				2'd1: heat_knot = rgb[2*CH_W-1:CH_W];
				2'd2: heat_knot = rgb[3*CH_W-1:2*CH_W];
				default: heat_knot = '0;
			endcase
		end
	endfunction

endpackage
`default_nettype wire

@@ hdl/pfcm_chan.sv @@
// One heat map channel: knot plus rounded delta times fraction.
`default_nettype none
module pfcm_chan #(
	parameter int FRAC_BITS = pfcm_pkg::FRAC_BITS_DEF
) (
	input  wire pfcm_pkg::chan_t  lo,
	input  wire pfcm_pkg::delta_t delta,
	input  wire [FRAC_BITS:0]     frac,
	output pfcm_pkg::chan_t       value
);
	import pfcm_pkg::*;

	localparam int PRW = CH_W + FRAC_BITS + 3;

	logic signed [PRW-1:0] d_ext;
	logic signed [PRW-1:0] f_ext;
	logic signed [PRW-1:0] prod;
	logic signed [PRW-1:0] half;
	logic signed [PRW-1:0] sum;
	logic signed [PRW-1:0] q;
	logic signed [PRW-1:0] res;

	always_comb begin
		d_ext = PRW'(delta);
		f_ext = $signed(PRW'(frac));
		half  = $signed(PRW'(1) << (FRAC_BITS - 1));
		prod  = d_ext * f_ext;
		sum   = prod + half;
		q     = sum >>> FRAC_BITS;
		res   = q + $signed(PRW'(lo));
		value = res[CH_W-1:0];
	end

endmodule
`default_nettype wire

@@ hdl/pixel_false_color_mapper.sv @@
// Top level: pixel to RGB false color mapper, five-stage pipeline.
//
//  channel   dir  handshake                        beat contents
//  s_axis    in   s_axis_tvalid / s_axis_tready    tdata[15:0] pixel
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata[23:0] red, green, blue
//  cfg       in   cfg_valid / cfg_ready            cfg_index, cfg_data
//
//  One beat per clock sustained while m_axis_tready stays high; each beat passes through stages 1 to 5 in order.
//  p/max is formed as the repeating binary fraction of p, built by shift-or doubling.
//  Each stage has its own valid and takes a beat when it is empty or its successor moves.
//  Reset clears stage valids; bit_depth resets to 8, color_mode to grey. cfg_ready is always high.
`default_nettype none
`include "pixel_false_color_mapper_macros.svh"
module pixel_false_color_mapper #(
	parameter int PIXEL_BITS = pfcm_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = pfcm_pkg::FRAC_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [pfcm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [pfcm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire [pfcm_pkg::PIX_W-1:0]        s_axis_tdata,   // [15:0] pixel
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [3*pfcm_pkg::CH_W-1:0]      m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
	import pfcm_pkg::*;

	localparam int PW   = PIXEL_BITS;
	localparam int DW   = $clog2(PW + 1);
	localparam int XW   = PW + FRAC_BITS + 4;
	localparam int SHW  = $clog2(XW + 1);
	localparam int NDBL = $clog2(XW);
	localparam int HDBL = NDBL / 2;
	localparam int SAW  = DW + NDBL;
	localparam int UW   = FRAC_BITS + 4;
	localparam int GW   = XW + 9;

	// config registers
	logic [DEPTH_W-1:0] bit_depth_q;
	logic [MODE_W-1:0]  color_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q  <= DEPTH_RESET;
			color_mode_q <= MODE_GREY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BIT_DEPTH:  bit_depth_q  <= cfg_data[DEPTH_W-1:0];
				REG_COLOR_MODE: color_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || m_axis_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: depth clamp, full scale, pixel clamp, mode decode
	logic [DW-1:0] d_eff;
	logic [PW-1:0] maxv;
	logic [PW-1:0] p_cl;
	logic          sat;

	always_comb begin
		if (bit_depth_q == '0)
			d_eff = DW'(1);
		else if (bit_depth_q > DEPTH_W'(PW))
			d_eff = DW'(PW);
		else
			d_eff = bit_depth_q[DW-1:0];
		maxv = {PW{1'b1}} >> (DW'(PW) - d_eff);
		p_cl = (s_axis_tdata > PIX_W'(maxv)) ? maxv : s_axis_tdata[PW-1:0];
		sat  = (p_cl >= maxv - PW'(1));
	end

	logic [PW-1:0] p_s1;
	logic [DW-1:0] d_s1;
	logic          heat_s1, red_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			p_s1    <= p_cl;
			d_s1    <= d_eff;
			heat_s1 <= (color_mode_q == MODE_HEAT);
			red_s1  <= (color_mode_q == MODE_SAT) && sat;
		end
	end

	// stage 2: align p at the binary point, first doublings of the repeat
	logic [XW-1:0] y_a;

	always_comb begin
		y_a = XW'(p_s1) << (SHW'(XW) - SHW'(d_s1));
		for (int k = 0; k < HDBL; k++)
			y_a = y_a | (y_a >> (SAW'(d_s1) << k));
	end

	logic [XW-1:0] y_s2;
	logic [DW-1:0] d_s2;
	logic          heat_s2, red_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			y_s2    <= y_a;
			d_s2    <= d_s1;
			heat_s2 <= heat_s1;
			red_s2  <= red_s1;
		end
	end

	// stage 3: remaining doublings, x = p/max truncated to XW fraction bits
	logic [XW-1:0] y_b;

	always_comb begin
		y_b = y_s2;
		for (int k = HDBL; k < NDBL; k++)
			y_b = y_b | (y_b >> (SAW'(d_s2) << k));
	end

	logic [XW-1:0] x_s3;
	logic          heat_s3, red_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			x_s3    <= y_b;
			heat_s3 <= heat_s2;
			red_s3  <= red_s2;
		end
	end

	// stage 4: grey level, heat position, segment, fraction, knots
	logic [GW-1:0]        gv;
	logic [UW-1:0]        xh;
	logic [UW:0]          xh1;
	logic [UW-1:0]        u;
	logic [UW-1:0]        um1;
	logic [2:0]           seg;
	logic [UW-1:0]        f_full;
	chan_t                lo_c [3];
	chan_t                hi_c [3];
	delta_t               dl_c [3];

	always_comb begin
		gv     = (GW'(x_s3) << 8) - GW'(x_s3) + (GW'(1) << (XW - 1));
		xh     = x_s3[XW-1 -: UW];
		xh1    = {1'b0, xh} + (UW + 1)'(1);
		u      = xh1[UW:1];
		um1    = u - UW'(1);
		seg    = (u == '0) ? 3'd0 : um1[FRAC_BITS+2:FRAC_BITS];
		f_full = u - (UW'(seg) << FRAC_BITS);
		for (int c = 0; c < 3; c++) begin
			lo_c[c] = heat_knot({1'b0, seg}, 2'(c));
			hi_c[c] = heat_knot({1'b0, seg} + 4'd1, 2'(c));
			dl_c[c] = $signed({1'b0, hi_c[c]}) - $signed({1'b0, lo_c[c]});
		end
	end

	chan_t              grey_s4;
	chan_t              lo_s4 [3];
	delta_t             dl_s4 [3];
	logic [FRAC_BITS:0] fr_s4;
	logic               heat_s4, red_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			grey_s4 <= gv[XW+CH_W-1:XW];
			fr_s4   <= f_full[FRAC_BITS:0];
			heat_s4 <= heat_s3;
			red_s4  <= red_s3;
			for (int c = 0; c < 3; c++) begin
				lo_s4[c] <= lo_c[c];
				dl_s4[c] <= dl_c[c];
			end
		end
	end

	// stage 5: heat interpolation and output select
	chan_t hv [3];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		pfcm_chan #(
			.FRAC_BITS (FRAC_BITS)
		) u_chan (
			.lo    (lo_s4[c]),
			.delta (dl_s4[c]),
			.frac  (fr_s4),
			.value (hv[c])
		);
	end

	logic [3*CH_W-1:0] rgb_n;
	logic [3*CH_W-1:0] rgb_s5;

	always_comb begin
		if (heat_s4)
			rgb_n = {hv[CH_BLUE], hv[CH_GREEN], hv[CH_RED]};
		else if (red_s4)
			rgb_n = {CH_W'(0), CH_W'(0), {CH_W{1'b1}}};
		else
			rgb_n = {grey_s4, grey_s4, grey_s4};
	end

	always_ff @(posedge clk) begin
		if (rdy5)
			rgb_s5 <= rgb_n;
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = rgb_s5;

	// checks
	`PFCM_ASSERT_NXT(a_s4_hold, v_s4 && !rdy5, v_s4 && $stable(grey_s4) && $stable(fr_s4))
	`PFCM_ASSERT_IMP(a_full_stall, !s_axis_tready, v_s1 && v_s2 && v_s3 && v_s4 && v_s5)
	`PFCM_ASSERT_IMP(a_frac_range, v_s4 && heat_s4, fr_s4 <= ((FRAC_BITS + 1)'(1) << FRAC_BITS))

endmodule
`default_nettype wire

@@ tb/sv/tb_pixel_false_color_mapper.sv @@
// Testbench for the false color mapper: directed and random streams checked against a color predictor.
`timescale 1ns / 100ps
module tb_pixel_false_color_mapper;
	import pfcm_pkg::*;

	localparam int FRAC      = FRAC_BITS_DEF;
	localparam int SEG_LEN   = 1 << FRAC;
	localparam int MAX_DEPTH = PIXEL_BITS_DEF;
	localparam int DRAIN_CYC = 12;
	localparam int HOLD_CYC  = 300;
	localparam int RAND_ITEMS = 1200;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam int HEAT_KNOTS [9][3] = '{
		'{0, 0, 0}, '{47, 50, 140}, '{0, 196, 255}, '{90, 190, 34}, '{255, 225, 0},
		'{240, 140, 11}, '{255, 0, 0}, '{236, 19, 142}, '{255, 255, 255}
	};

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	class color_scoreboard;
		logic [DEPTH_W-1:0] depth;
		logic [MODE_W-1:0]  mode;
		rgb_t               color_q[$];
		int                 errors;

		function new();
			depth = DEPTH_RESET;
			mode = MODE_GREY;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_BIT_DEPTH) begin
				depth = val;
			end else if (idx == REG_COLOR_MODE) begin
				mode = val[MODE_W-1:0];
			end
		endfunction

		function int pending();
			return color_q.size();
		endfunction

		static function logic [CH_W-1:0] heat_mix(int lo, int hi, int frac);
			int v;
			v = lo + (((hi - lo) * frac + SEG_LEN / 2) >>> FRAC);
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			return v[CH_W-1:0];
		endfunction

		function rgb_t predict_rgb(logic [PIX_W-1:0] pixel);
			int unsigned d, full, p, u, grey;
			int seg, frac;
			rgb_t c;
			d = (depth == 0) ? 1 : (depth > MAX_DEPTH) ? MAX_DEPTH : depth;
			full = (1 << d) - 1;
			p = (pixel > full) ? full : pixel;
			if (mode == MODE_HEAT) begin
				u = (2 * p * (8 * SEG_LEN) + full) / (2 * full);
				seg = 0;
				frac = 0;
				if (u > 0) begin
					seg = ((u - 1) >> FRAC) & 7;
					frac = u - seg * SEG_LEN;
				end
				c.red   = heat_mix(HEAT_KNOTS[seg][0], HEAT_KNOTS[seg+1][0], frac);
				c.green = heat_mix(HEAT_KNOTS[seg][1], HEAT_KNOTS[seg+1][1], frac);
				c.blue  = heat_mix(HEAT_KNOTS[seg][2], HEAT_KNOTS[seg+1][2], frac);
			end else if (mode == MODE_SAT && p + 1 >= full) begin
				c.red = 8'd255;
				c.green = 8'd0;
				c.blue = 8'd0;
			end else begin
				grey = (2 * p * 255 + full) / (2 * full);
				c.red = grey[CH_W-1:0];
				c.green = grey[CH_W-1:0];
				c.blue = grey[CH_W-1:0];
			end
			return c;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] pixel);
			color_q.push_back(predict_rgb(pixel));
		endfunction

		function void check_rgb(rgb_t got);
			rgb_t want;
			if (color_q.size() == 0) begin
				$error("output beat %h with no pixel pending", got);
				errors++;
				return;
			end
			want = color_q.pop_front();
			if (got.red !== want.red) begin
				$error("red: expected %0d, got %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, got %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, got.blue);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata = '0;   // [15:0] pixel
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [3*CH_W-1:0]     m_axis_tdata;        // [7:0] red, [15:8] green, [23:16] blue

	color_scoreboard sb = new();
	bit hold_req = 1'b0;
	int cycle_count = 0;

	pixel_false_color_mapper dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_rgb(m_axis_tdata);
		end
	end

	// output side: tready follows a randomly chosen stall pattern, held low for a while when hold_req is set
	initial begin
		int style;
		int style_left;
		style = 0;
		style_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
			end
			if (style_left == 0) begin
				style = $urandom_range(0, 3);
				style_left = $urandom_range(16, 128);
			end
			style_left--;
			case (style)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 7) != 0);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] pixel);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pixel;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_pixel(pixel);
	endtask

	task automatic pause_input(input int cycles);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain_pipe();
		pause_input(1);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [DEPTH_W-1:0] depth, input logic [MODE_W-1:0] mode);
		drain_pipe();
		write_reg(REG_BIT_DEPTH, depth);
		write_reg(REG_COLOR_MODE, CFG_DATA_W'(mode));
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(input logic [DEPTH_W-1:0] depth);
		int unsigned d, full, k, v;
		d = (depth == 0) ? 1 : (depth > MAX_DEPTH) ? MAX_DEPTH : depth;
		full = (1 << d) - 1;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom_range(0, 65535);
			2, 3, 4, 5: v = $urandom_range(0, full);
			6, 7: v = full + $urandom_range(0, 4) - 2;
			8: begin
				k = $urandom_range(1, 7);
				v = (k * full + 4) / 8 + $urandom_range(0, 2) - 1;
			end
			default: v = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 1 : 65535);
		endcase
		if (v > 65535) v = ($urandom_range(0, 1)) ? 65535 : 0;
		return v[PIX_W-1:0];
	endfunction

	task automatic send_random(input logic [DEPTH_W-1:0] depth, input int count,
			input bit no_gaps, input bit mid_drain);
		int burst_left;
		burst_left = $urandom_range(1, 16);
		for (int i = 0; i < count; i++) begin
			if (mid_drain && i == count / 2) begin
				drain_pipe();
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				if (!no_gaps) pause_input($urandom_range(1, 6));
			end
			burst_left--;
			send_pixel(pick_pixel(depth));
		end
	endtask

	initial begin
		logic [DEPTH_W-1:0] depth;
		logic [MODE_W-1:0] mode;
		int sent;
		int phase;
		int count;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: depth 8, grey, incl. clamp above full scale
		send_pixel(16'd0);
		send_pixel(16'd128);
		send_pixel(16'd255);
		send_pixel(16'd256);
		send_pixel(16'hFFFF);

		set_config(5'd16, MODE_SAT);
		send_pixel(16'd0);
		send_pixel(16'd65533);
		send_pixel(16'd65534);
		send_pixel(16'd65535);

		// one-bit depth: every pixel is saturated
		set_config(5'd1, MODE_SAT);
		send_pixel(16'd0);
		send_pixel(16'd1);

		// heat map incl. segment boundaries
		set_config(5'd16, MODE_HEAT);
		send_pixel(16'd0);
		send_pixel(16'd8192);
		send_pixel(16'd16384);
		send_pixel(16'd40000);
		send_pixel(16'd65535);

		set_config(5'd0, MODE_HEAT);
		send_pixel(16'd0);
		send_pixel(16'd1);

		set_config(5'd31, MODE_UNUSED);
		send_pixel(16'd32768);
		send_pixel(16'd65535);

		set_config(5'd12, MODE_HEAT);
		send_pixel(16'd2047);
		send_pixel(16'd4095);
		send_pixel(16'd5000);

		sent = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			case ($urandom_range(0, 5))
				0: begin
					case ($urandom_range(0, 3))
						0: depth = 5'd0;
						1: depth = 5'd1;
						2: depth = 5'd16;
						default: depth = 5'd31;
					endcase
				end
				default: depth = DEPTH_W'($urandom_range(0, 31));
			endcase
			mode = (phase == 2) ? MODE_HEAT : MODE_W'($urandom_range(0, 3));
			set_config(depth, mode);
			count = $urandom_range(30, 90);
			if (phase == 2) begin
				hold_req = 1'b1;
				send_random(depth, count, 1'b1, 1'b0);
			end else begin
				send_random(depth, count, $urandom_range(0, 3) == 0, phase == 4);
			end
			sent += count;
			phase++;
		end

		pause_input(1);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/pfcm_pkg.sv
hdl/pfcm_chan.sv
hdl/pixel_false_color_mapper.sv
tb/sv/tb_pixel_false_color_mapper.sv
